// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/plir_pkg.sv =====
// Types, constants and codes for the positional list block.
`default_nettype none

package plir_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int PLACED_W = 4;
  localparam int ECNT_W   = 5;

  // Working width for count and position compares
  localparam int SUM_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

  // Stream payload layout
  localparam int IN_DATA_W  = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_BITS   = STAT_W + VAL_W + PLACED_W + ECNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOPOS = 2'd3;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plir_cell.sv =====
// One storage cell of the list chain: holds, loads, or takes a neighbor's word.
`default_nettype none

module plir_cell (
  input  wire                   clk,
  input  wire plir_pkg::ctrl_t  ctrl,
  input  wire [plir_pkg::IDX_W-1:0] my_index,
  input  wire [plir_pkg::VAL_W-1:0] left_data,
  input  wire [plir_pkg::VAL_W-1:0] right_data,
  output logic [plir_pkg::VAL_W-1:0] data
);
  import plir_pkg::*;

  // Insert shifts up from the left neighbor, remove shifts down from the right
  always_ff @(posedge clk) begin
    if (ctrl.ins && (my_index > ctrl.pos)) begin
      data <= left_data;
    end else if (ctrl.ins && (my_index == ctrl.pos)) begin
      data <= ctrl.value;
    end else if (ctrl.rem && (my_index >= ctrl.pos)) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plir_ctrl.sv =====
// Operation decode: status, effective position and next count.
`default_nettype none

module plir_ctrl (
  input  wire                         fire,
  input  wire [plir_pkg::OP_W-1:0]    operation,
  input  wire [plir_pkg::POS_W-1:0]   position,
  input  wire [plir_pkg::VAL_W-1:0]   value,
  input  wire [plir_pkg::CNT_W-1:0]   count,
  output plir_pkg::ctrl_t             ctrl,
  output logic                        rd_ok,
  output logic [plir_pkg::STAT_W-1:0] status,
  output logic [plir_pkg::PLACED_W-1:0] placed_at,
  output logic [plir_pkg::CNT_W-1:0]  count_next
);
  import plir_pkg::*;

  logic [SUM_W-1:0] cnt_w;
  logic [SUM_W-1:0] pos_w;
  logic [SUM_W-1:0] pos_eff;
  logic             ins;
  logic             rem;

  assign cnt_w = SUM_W'(count);
  assign pos_w = SUM_W'(position);

  always_comb begin
    ins     = 1'b0;
    rem     = 1'b0;
    rd_ok   = 1'b0;
    status  = ST_OK;
    pos_eff = pos_w;
    case (operation)
      OP_INSERT: begin
        if (cnt_w >= SUM_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          // past the end appends at the tail
          pos_eff = (pos_w > cnt_w) ? cnt_w : pos_w;
          ins     = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cnt_w == '0) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_NOPOS;
        end else begin
          rem = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_w >= cnt_w) begin
          status = ST_NOPOS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        // unused code: no change, status ok
      end
    endcase
  end

  assign placed_at = ins ? pos_eff[PLACED_W-1:0] : '0;

  always_comb begin
    count_next = count;
    if (ins) begin
      count_next = count + CNT_W'(1);
    end else if (rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Broadcast control: ins, rem, pos, value from the top bit down
  assign ctrl = {fire & ins, fire & rem, pos_eff[IDX_W-1:0], value};

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_insert_remove.sv =====
// An accepted input transaction shows its result on the master side in the next cycle.
// Throughput: one operation per cycle while the master takes results; all cells shift together.
// The output register frees as it is taken, so input is stalled only by master backpressure.
// Reset (rst, synchronous, active high) empties the list and drops any pending result.
// Entry cells have no reset; a cell is only read once an insert has written it.
// Top level of the positional list with insert, remove and read at an index.
`default_nettype none

module positional_list_insert_remove (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: operation[1:0], position[5:2], value[37:6], zero fill
  input  wire [plir_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: status[1:0], read_value[33:2], placed_at[37:34], entry_count[42:38], zero fill
  output logic [plir_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import plir_pkg::*;

  logic [OP_W-1:0]     operation;
  logic [POS_W-1:0]    position;
  logic [VAL_W-1:0]    value;
  logic                fire;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  ctrl_t               ctrl;
  logic                rd_ok;
  logic [STAT_W-1:0]   status;
  logic [PLACED_W-1:0] placed_at;
  logic [VAL_W-1:0]    read_value;
  logic [VAL_W-1:0]    cell_data [CAPACITY];

  // Unpack input payload
  assign operation = s_axis_tdata[OP_W-1:0];
  assign position  = s_axis_tdata[OP_W +: POS_W];
  assign value     = s_axis_tdata[OP_W+POS_W +: VAL_W];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  plir_ctrl u_ctrl (
    .fire       (fire),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .count      (count),
    .ctrl       (ctrl),
    .rd_ok      (rd_ok),
    .status     (status),
    .placed_at  (placed_at),
    .count_next (count_next)
  );

  // Chain of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_in;
    logic [VAL_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    plir_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .my_index   (IDX_W'(i)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i])
    );
  end

  // Read tap from the current contents
  assign read_value = rd_ok ? cell_data[ctrl.pos] : '0;

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= OUT_DATA_W'({ECNT_W'(count_next), placed_at, read_value, status});
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plir_checker.sv =====
// Port-level checker for the positional list, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module plir_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [plir_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import plir_pkg::*;

  logic [STAT_W-1:0] o_status;
  logic [VAL_W-1:0]  o_read;
  logic [ECNT_W-1:0] o_count;
  logic              in_xact;

  assign o_status = m_axis_tdata[STAT_W-1:0];
  assign o_read   = m_axis_tdata[STAT_W +: VAL_W];
  assign o_count  = m_axis_tdata[STAT_W+VAL_W+PLACED_W +: ECNT_W];
  assign in_xact  = s_axis_tvalid && s_axis_tready;

  // A full report always comes with a full count
  `ASSERT_IMP(a_full_count, clk, rst, m_axis_tvalid && (o_status == ST_FULL),
    o_count == ECNT_W'(CAPACITY), "full status without full count")

  // An error status always comes with a zero read word
  `ASSERT_IMP(a_read_zero, clk, rst, m_axis_tvalid && (o_status != ST_OK),
    o_read == '0, "read_value nonzero on error status")

  // Every accepted transaction shows a result in the next cycle
  `ASSERT_NXT(a_result_follows, clk, rst, in_xact, m_axis_tvalid,
    "no result after accepted transaction")

  // A stalled result holds
  `ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Reset drops any pending result
  `ASSERT_NXT_ALWAYS(a_reset_clear, clk, rst, !m_axis_tvalid,
    "result valid after reset")

endmodule

bind positional_list_insert_remove plir_checker u_plir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
